// ===== rtl/core/stb_pkg.sv =====
// Shared types and constants for the software timer bank.
// No dependencies; stb_dec, stb_seq and software_timer_bank import this package.
`default_nettype none

package stb_pkg;

	localparam int unsigned DATA_W         = 32;
	localparam int unsigned ID_W           = 8;
	localparam int unsigned CMD_W          = 3;
	localparam int unsigned DEF_NUM_TIMERS = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_AUTO  = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_CHECK = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DONE
	} seq_state_t;

	// Control flags from the sequencer to the datapath.
	typedef struct packed {
		logic busy;
		logic wb_en;
		logic load_out;
	} seq_ctrl_t;

	// Result of the shared countdown unit for one timer entry.
	typedef struct packed {
		logic              wr;
		logic              expire;
		logic [DATA_W-1:0] value;
	} dec_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/stb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the count and preload stores.
`default_nettype none

module stb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/stb_dec.sv =====
// Shared countdown unit: decrements one timer entry and handles expiry and reload.
// Depends on stb_pkg.
`default_nettype none

module stb_dec
	import stb_pkg::*;
(
	input  wire logic [DATA_W-1:0] remaining,
	input  wire logic [DATA_W-1:0] reload_value,
	input  wire logic              auto_mode,
	output dec_res_t               res
);

	logic [DATA_W-1:0] dec_val;

	always_comb begin
		dec_val    = remaining - DATA_W'(1);
		res.wr     = (remaining != '0);
		res.expire = res.wr && (dec_val == '0);
		if (res.expire && auto_mode) begin
			res.value = reload_value;
		end else begin
			res.value = dec_val;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/stb_seq.sv =====
// Sequencer for the timer bank: accepts commands and walks the entries on a tick.
// Depends on stb_pkg.
`default_nettype none

module stb_seq
	import stb_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS,
	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_fire,
	input  wire logic             is_tick,
	input  wire logic             out_free,
	output logic      [IDX_W-1:0] rd_idx,
	output logic      [IDX_W-1:0] wb_idx,
	output seq_ctrl_t             ctrl
);

	localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);

	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             pend_s1, pend_d;
	logic [IDX_W-1:0] idx_s1, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_d;
	end

	// A read issued at one index returns in the next cycle, when the entry is written
	// back while the next index is read.
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		pend_d        = 1'b0;
		idx_d         = idx_s1;
		rd_idx        = '0;
		ctrl.busy     = (state_q != ST_IDLE);
		ctrl.wb_en    = pend_s1;
		ctrl.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cnt_d   = '0;
					state_d = is_tick ? ST_TICK : ST_DONE;
				end
			end
			ST_TICK: begin
				if (cnt_q != CNT_W'(NUM_TIMERS)) begin
					rd_idx = cnt_q[IDX_W-1:0];
					pend_d = 1'b1;
					idx_d  = cnt_q[IDX_W-1:0];
					cnt_d  = cnt_q + CNT_W'(1);
				end else if (!pend_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				ctrl.load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign wb_idx = idx_s1;

endmodule

`default_nettype wire

// ===== rtl/core/software_timer_bank.sv =====
// Top level of the software timer bank: command port, timer stores and result register.
// Depends on stb_pkg, stb_ram, stb_dec and stb_seq.
//
//   Channel  Signals                           Direction
//   in       in_valid, in_stall, command,      command beat into the bank
//            timer_id, period
//   out      out_valid, out_stall, expired,    one result beat per command
//            run_time
//
// Start, stop, check and undefined commands go from IDLE to DONE, which loads the
// output register once it is free; the bank then returns to IDLE for the next command.
// A tick first walks all NUM_TIMERS entries in TICK: the one shared decrementer
// visits one entry per cycle, with the count store read in the cycle before its
// write-back. in_stall is high while a command is in progress.
// A new command is accepted while an earlier result still waits in the output
// register. Reset clears all timers through per-entry valid bits, with no sweep.
`default_nettype none

module software_timer_bank
	import stb_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [ID_W-1:0]   timer_id,
	input  wire logic [DATA_W-1:0] period,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   expired,
	output logic      [DATA_W-1:0] run_time
);

	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	seq_ctrl_t         ctrl;
	dec_res_t          dec;
	cmd_t              cmd;
	logic              in_fire;
	logic              out_free;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  wb_idx;
	logic [IDX_W-1:0]  sel_idx;
	logic              id_in_range;
	logic [DATA_W-1:0] rem_rdata;
	logic [DATA_W-1:0] rel_rdata;
	logic [DATA_W-1:0] rem_cur;
	logic [DATA_W-1:0] rel_cur;
	logic              rem_we;
	logic [IDX_W-1:0]  rem_waddr;
	logic [DATA_W-1:0] rem_wdata;
	logic              rel_we;
	logic              is_start;
	logic              is_stop;

	logic [NUM_TIMERS-1:0] valid_q;
	logic [NUM_TIMERS-1:0] flag_q;
	logic [NUM_TIMERS-1:0] auto_q;
	logic [DATA_W-1:0]     tick_q;
	logic                  exp_q;
	logic                  out_valid_q;
	logic                  expired_q;
	logic [DATA_W-1:0]     run_time_q;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = ctrl.busy;
	assign out_free = !out_valid_q || !out_stall;
	assign cmd      = cmd_t'(command);

	assign id_in_range = ({1'b0, timer_id} < (ID_W + 1)'(NUM_TIMERS));
	assign sel_idx     = id_in_range ? IDX_W'(timer_id) : IDX_W'(NUM_TIMERS - 1);

	always_comb begin
		is_start = 1'b0;
		is_stop  = 1'b0;
		unique case (cmd)
			CMD_START, CMD_AUTO: is_start = 1'b1;
			CMD_STOP:            is_stop  = 1'b1;
			default: ;
		endcase
	end

	stb_seq #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.is_tick (cmd == CMD_TICK),
		.out_free(out_free),
		.rd_idx  (rd_idx),
		.wb_idx  (wb_idx),
		.ctrl    (ctrl)
	);

	// An entry never started reads as zero in both stores.
	assign rem_cur = valid_q[wb_idx] ? rem_rdata : '0;
	assign rel_cur = valid_q[wb_idx] ? rel_rdata : '0;

	stb_dec u_dec (
		.remaining   (rem_cur),
		.reload_value(rel_cur),
		.auto_mode   (auto_q[wb_idx]),
		.res         (dec)
	);

	always_comb begin
		if (ctrl.wb_en) begin
			rem_we    = dec.wr;
			rem_waddr = wb_idx;
			rem_wdata = dec.value;
		end else begin
			rem_we    = in_fire && (is_start || is_stop);
			rem_waddr = sel_idx;
			rem_wdata = is_start ? period : '0;
		end
		rel_we = in_fire && is_start;
	end

	stb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_TIMERS)
	) u_rem_ram (
		.clk  (clk),
		.we   (rem_we),
		.waddr(rem_waddr),
		.wdata(rem_wdata),
		.raddr(rd_idx),
		.rdata(rem_rdata)
	);

	stb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_TIMERS)
	) u_rel_ram (
		.clk  (clk),
		.we   (rel_we),
		.waddr(sel_idx),
		.wdata(period),
		.raddr(rd_idx),
		.rdata(rel_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			flag_q  <= '0;
			auto_q  <= '0;
			tick_q  <= '0;
			exp_q   <= 1'b0;
		end else begin
			if (ctrl.wb_en && dec.expire) begin
				flag_q[wb_idx] <= 1'b1;
			end
			if (in_fire) begin
				exp_q <= 1'b0;
				unique case (cmd)
					CMD_TICK: begin
						tick_q <= tick_q + DATA_W'(1);
					end
					CMD_START, CMD_AUTO: begin
						valid_q[sel_idx] <= 1'b1;
						flag_q[sel_idx]  <= 1'b0;
						auto_q[sel_idx]  <= (cmd == CMD_AUTO);
					end
					CMD_STOP: begin
						flag_q[sel_idx] <= 1'b0;
						auto_q[sel_idx] <= 1'b0;
					end
					CMD_CHECK: begin
						if (id_in_range) begin
							exp_q           <= flag_q[sel_idx];
							flag_q[sel_idx] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			expired_q  <= exp_q;
			run_time_q <= tick_q;
		end
	end

	assign out_valid = out_valid_q;
	assign expired   = expired_q;
	assign run_time  = run_time_q;

`ifndef SYNTH
	// Every accepted command keeps the sequencer busy on the following cycle.
	a_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> ctrl.busy)
		else $error("command accepted but sequencer not busy");

	// A nonzero count can only belong to an entry that has been started.
	a_wb_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wb_en && dec.wr) |-> valid_q[wb_idx])
		else $error("countdown on an entry never started");

	// The result register is only loaded when its previous beat is gone.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");

	// A new result beat appears only after the sequencer finished a command.
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.load_out))
		else $error("result beat without a finished command");
`endif

endmodule

`default_nettype wire
